// ===== rtl/core/vector_field_divergence_unit_assert.svh =====
// Assertion macros for the core RTL (included by vfd_calc).
// Every macro samples on posedge clk and is disabled while rst_n is low.
`ifndef VECTOR_FIELD_DIVERGENCE_UNIT_ASSERT_SVH
`define VECTOR_FIELD_DIVERGENCE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define VFD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define VFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/vfd_pkg.sv =====
`timescale 1ns / 1ps
package vfd_pkg;

  localparam int ROWS_MAX = 1024;
  localparam int ROW_W    = $clog2(ROWS_MAX);
  localparam int CNT_W    = ROW_W + 1;
  localparam int RCFG_W   = 11;
  localparam int CMP_W    = (CNT_W > RCFG_W) ? CNT_W : RCFG_W;
  localparam int SMP_W    = 16;
  localparam int RES_W    = 19;

  localparam logic [RCFG_W-1:0] ROWS_RESET = RCFG_W'(2);

  typedef logic signed [SMP_W-1:0] sample_t;
  typedef logic [ROW_W-1:0]        row_t;

  typedef enum logic [1:0] {
    REQ_SAMPLE = 2'd0,
    REQ_FLUSH  = 2'd1,
    REQ_FINAL  = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_LATER  = 2'd2
  } phase_t;

  // One line-buffer entry: v of the previous column, u of the previous two.
  typedef struct packed {
    sample_t v;
    sample_t u1;
    sample_t u2;
  } line_t;

  // Request as handed from the row sequencer to the stencil stage.
  typedef struct packed {
    logic    is_sample;
    logic    is_last;
    phase_t  phase;
    logic    first_row;
    logic    last_row;
    row_t    row;
    row_t    row_nb;
    sample_t u;
    sample_t v;
  } item_t;

  typedef struct packed {
    logic  we;
    row_t  addr;
    line_t data;
  } line_wr_t;

endpackage

// ===== rtl/core/vfd_in_if.sv =====
`timescale 1ns / 1ps
interface vfd_in_if;
  import vfd_pkg::*;

  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  sample_t     u_sample;
  sample_t     v_sample;

  modport source (output valid, output req_type, output u_sample, output v_sample,
                  input ready);
  modport sink   (input valid, input req_type, input u_sample, input v_sample,
                  output ready);
endinterface

// ===== rtl/core/vfd_out_if.sv =====
`timescale 1ns / 1ps
interface vfd_out_if;
  import vfd_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [RES_W-1:0] neg_div_x2;
  logic                    is_last;

  modport source (output valid, output neg_div_x2, output is_last, input ready);
  modport sink   (input valid, input neg_div_x2, input is_last, output ready);
endinterface

// ===== rtl/core/vfd_line_ram.sv =====
`timescale 1ns / 1ps
module vfd_line_ram (
  input  logic             clk,
  input  logic             re,
  input  vfd_pkg::row_t    ra_a,
  input  vfd_pkg::row_t    ra_b,
  input  vfd_pkg::line_wr_t wr,
  output vfd_pkg::line_t   rd_a,
  output vfd_pkg::line_t   rd_b
);
  import vfd_pkg::*;

  line_t mem [ROWS_MAX];
  line_t rd_a_r;
  line_t rd_b_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // read-before-write on a same-address collision; the stencil stage forwards
  always_ff @(posedge clk) begin
    if (re) begin
      rd_a_r <= mem[ra_a];
      rd_b_r <= mem[ra_b];
    end
  end

  assign rd_a = rd_a_r;
  assign rd_b = rd_b_r;
endmodule

// ===== rtl/core/vfd_ctrl.sv =====
`timescale 1ns / 1ps
module vfd_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [vfd_pkg::RCFG_W-1:0] cfg_wdata,
  vfd_in_if.sink                     in_ch,
  input  logic                       stage_free,
  output vfd_pkg::item_t             item,
  output logic                       item_load
);
  import vfd_pkg::*;

  logic [RCFG_W-1:0] rows_r;
  row_t              row_idx_r;
  row_t              row_idx_nxt;
  phase_t            phase_r;
  phase_t            phase_nxt;

  logic [CMP_W-1:0]  rows_ext;
  logic [CMP_W-1:0]  n_ext;
  logic [CNT_W-1:0]  n;
  row_t              r;
  row_t              r_inc;
  logic              end_col;
  logic              accept;
  logic              go_b;
  req_t              kind;

  assign in_ch.ready = stage_free;
  assign accept      = in_ch.valid && in_ch.ready;
  assign kind        = req_t'(in_ch.req_type);

  // effective row count, clamped to 2..ROWS_MAX
  always_comb begin
    rows_ext = CMP_W'(rows_r);
    if (rows_ext < CMP_W'(2)) begin
      n_ext = CMP_W'(2);
    end else if (rows_ext > CMP_W'(ROWS_MAX)) begin
      n_ext = CMP_W'(ROWS_MAX);
    end else begin
      n_ext = rows_ext;
    end
    n = CNT_W'(n_ext);
  end

  // a row index left past the end by a smaller row count sits on the last row
  always_comb begin
    logic [CNT_W-1:0] nm1;
    nm1 = n - CNT_W'(1);
    if ({1'b0, row_idx_r} >= n) begin
      r = nm1[ROW_W-1:0];
    end else begin
      r = row_idx_r;
    end
    end_col = ({1'b0, r} == nm1);
    r_inc   = r + ROW_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r    <= ROWS_RESET;
      row_idx_r <= '0;
      phase_r   <= PH_FIRST;
    end else begin
      if (cfg_we) begin
        rows_r <= cfg_wdata;
      end
      row_idx_r <= row_idx_nxt;
      phase_r   <= phase_nxt;
    end
  end

  always_comb begin
    row_idx_nxt = row_idx_r;
    phase_nxt   = phase_r;
    go_b        = 1'b0;
    if (accept) begin
      unique case (kind)
        REQ_SAMPLE: begin
          go_b        = 1'b1;
          row_idx_nxt = end_col ? '0 : r_inc;
          if (end_col) begin
            unique case (phase_r)
              PH_FIRST:  phase_nxt = PH_SECOND;
              PH_SECOND: phase_nxt = PH_LATER;
              default:   phase_nxt = phase_r;
            endcase
          end
        end
        REQ_FLUSH: begin
          go_b        = (phase_r == PH_LATER);
          row_idx_nxt = end_col ? '0 : r_inc;
        end
        REQ_FINAL: begin
          go_b        = (phase_r == PH_LATER);
          row_idx_nxt = '0;
          phase_nxt   = PH_FIRST;
        end
        default: begin
          go_b = 1'b0;
        end
      endcase
    end
  end

  assign item_load = go_b;

  always_comb begin
    item.is_sample = (kind == REQ_SAMPLE);
    item.is_last   = (kind == REQ_FINAL);
    item.phase     = phase_r;
    item.first_row = (r == '0);
    item.last_row  = end_col;
    item.row       = r;
    item.row_nb    = (r == '0) ? ROW_W'(1) : r_inc;
    item.u         = in_ch.u_sample;
    item.v         = in_ch.v_sample;
  end
endmodule

// ===== rtl/core/vfd_calc.sv =====
`timescale 1ns / 1ps
`include "vector_field_divergence_unit_assert.svh"
module vfd_calc (
  input  logic              clk,
  input  logic              rst_n,
  input  vfd_pkg::item_t    item,
  input  logic              item_load,
  input  vfd_pkg::line_t    rd_a,
  input  vfd_pkg::line_t    rd_b,
  output vfd_pkg::line_wr_t wr,
  output logic              stage_free,
  vfd_out_if.source         out_ch
);
  import vfd_pkg::*;

  item_t                   b_r;
  logic                    b_valid_r;
  logic                    wb_valid_r;
  row_t                    wb_addr_r;
  line_t                   wb_word_r;
  sample_t                 vw1_r;
  logic                    out_valid_r;
  logic signed [RES_W-1:0] out_neg_r;
  logic                    out_last_r;

  line_t                   word_a;
  line_t                   word_b;
  logic                    emit;
  logic                    b_go;
  logic signed [17:0]      du;
  logic signed [17:0]      dv;
  logic signed [RES_W-1:0] sum;
  logic signed [RES_W-1:0] neg;

  assign emit       = b_r.is_sample ? (b_r.phase != PH_FIRST) : 1'b1;
  assign b_go       = b_valid_r && (!emit || !out_valid_r || out_ch.ready);
  assign stage_free = !b_valid_r || b_go;

  // the previous write may have landed on the read edge: take it from here
  assign word_a = (wb_valid_r && wb_addr_r == b_r.row)    ? wb_word_r : rd_a;
  assign word_b = (wb_valid_r && wb_addr_r == b_r.row_nb) ? wb_word_r : rd_b;

  always_comb begin
    wr.we      = b_go && b_r.is_sample;
    wr.addr    = b_r.row;
    wr.data.v  = b_r.v;
    wr.data.u1 = b_r.u;
    wr.data.u2 = word_a.u1;
  end

  // column direction: one-sided on the second column and on the flush column
  always_comb begin
    sample_t            a;
    sample_t            b;
    logic               dbl;
    logic signed [16:0] diff;
    if (!b_r.is_sample) begin
      a   = word_a.u1;
      b   = word_a.u2;
      dbl = 1'b1;
    end else if (b_r.phase == PH_SECOND) begin
      a   = b_r.u;
      b   = word_a.u1;
      dbl = 1'b1;
    end else begin
      a   = b_r.u;
      b   = word_a.u2;
      dbl = 1'b0;
    end
    diff = {a[SMP_W-1], a} - {b[SMP_W-1], b};
    du   = dbl ? {diff, 1'b0} : {diff[16], diff};
  end

  // row direction: one-sided on the first and last row
  always_comb begin
    sample_t            a;
    sample_t            b;
    logic signed [16:0] diff;
    a    = b_r.last_row  ? word_a.v : word_b.v;
    b    = b_r.first_row ? word_a.v : vw1_r;
    diff = {a[SMP_W-1], a} - {b[SMP_W-1], b};
    dv   = (b_r.first_row || b_r.last_row) ? {diff, 1'b0} : {diff[16], diff};
  end

  assign sum = {du[17], du} + {dv[17], dv};
  assign neg = -sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      wb_valid_r  <= 1'b0;
      vw1_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (item_load) begin
        b_valid_r <= 1'b1;
      end else if (b_go) begin
        b_valid_r <= 1'b0;
      end
      if (wr.we) begin
        wb_valid_r <= 1'b1;
      end
      if (b_go && emit) begin
        vw1_r       <= word_a.v;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_load) begin
      b_r <= item;
    end
    if (wr.we) begin
      wb_addr_r <= wr.addr;
      wb_word_r <= wr.data;
    end
    if (b_go && emit) begin
      out_neg_r  <= neg;
      out_last_r <= b_r.is_last;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.neg_div_x2 = out_neg_r;
  assign out_ch.is_last    = out_last_r;

  `VFD_ASSERT_IMPL(a_flush_late_phase, b_valid_r && !b_r.is_sample, b_r.phase == PH_LATER, "flush request in stencil stage before two columns")
  `VFD_ASSERT_IMPL(a_last_is_flush, b_valid_r && b_r.is_last, !b_r.is_sample, "end-of-matrix mark on a sample request")
  `VFD_ASSERT_NEXT(a_stage_holds, b_valid_r && !b_go, b_valid_r && $stable(b_r), "stalled stencil stage lost its request")
  `VFD_ASSERT_IMPL(a_load_when_free, item_load, stage_free, "request loaded into a busy stencil stage")
endmodule

// ===== rtl/core/vector_field_divergence_unit.sv =====
`timescale 1ns / 1ps
// Channel   Dir  Payload                          Request taken when
// in_ch     in   req_type, u_sample, v_sample     in_ch.valid && in_ch.ready
// out_ch    out  neg_div_x2, is_last              out_ch.valid && out_ch.ready
// cfg_*     in   cfg_wdata (rows)                 cfg_we
//
// One request per cycle sustained while out_ch is not stalled; each result passes the
// line RAM read register, then the stencil add and the output register.
// Line RAM: 1024 x 48 bits, one write and two reads per cycle; a write landing on
// the read edge of the next request is forwarded.
// Reset (synchronous): rows = 2, first column, row zero; line RAM is not cleared.
// A stalled output holds the stencil stage, and in_ch.ready drops only then.
module vector_field_divergence_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [vfd_pkg::RCFG_W-1:0] cfg_wdata,
  vfd_in_if.sink                     in_ch,
  vfd_out_if.source                  out_ch
);
  import vfd_pkg::*;

  item_t    item;
  logic     item_load;
  logic     stage_free;
  line_t    rd_a;
  line_t    rd_b;
  line_wr_t wr;

  vfd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_ch      (in_ch),
    .stage_free (stage_free),
    .item       (item),
    .item_load  (item_load)
  );

  vfd_line_ram u_line_ram (
    .clk  (clk),
    .re   (item_load),
    .ra_a (item.row),
    .ra_b (item.row_nb),
    .wr   (wr),
    .rd_a (rd_a),
    .rd_b (rd_b)
  );

  vfd_calc u_calc (
    .clk        (clk),
    .rst_n      (rst_n),
    .item       (item),
    .item_load  (item_load),
    .rd_a       (rd_a),
    .rd_b       (rd_b),
    .wr         (wr),
    .stage_free (stage_free),
    .out_ch     (out_ch)
  );
endmodule
